[rtl/assert_macros.svh]
// assertion macros used by note_sequencer_triangle_synth_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[rtl/nsts_pkg.sv]
// constants, types and tables for the note sequencer triangle synth
// no dependencies
package nsts_pkg;

    localparam int SAMPLE_RATE  = 44100;
    localparam int PHASE_BITS   = 32;
    localparam int OCTAVE_LIMIT = 4;

    localparam int VOL_W  = 15;
    localparam int SL_W   = 17;
    localparam int OCT_W  = 4;
    localparam int DUR_W  = 3;
    localparam int CHR_W  = 8;
    localparam int SMP_W  = 16;
    localparam int NOTE_N = 12;
    localparam int NIDX_W = $clog2(NOTE_N);

    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(30000);
    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(2);
    localparam logic [DUR_W-1:0] DUR_MAX   = DUR_W'(4);
    localparam logic [SL_W-1:0]  DUR_BASE  = SL_W'(2 * SAMPLE_RATE);

    localparam logic signed [OCT_W-1:0] OCT_MAX = OCT_W'(OCTAVE_LIMIT);
    localparam logic signed [OCT_W-1:0] OCT_MIN = -OCT_MAX;

    // table increments, rounded, frequencies in hundredths of a hertz
    localparam longint unsigned PH_ONE = 64'd1 << PHASE_BITS;
    localparam longint unsigned INC_RND = 64'(50 * SAMPLE_RATE);
    localparam longint unsigned INC_DEN = 64'(100 * SAMPLE_RATE);

    localparam logic [PHASE_BITS-1:0] NOTE_INC [NOTE_N] = '{
        PHASE_BITS'((64'd41530 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd44000 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd46616 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd49388 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd52325 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd55437 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd58733 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd62225 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd65926 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd69846 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd73999 * PH_ONE + INC_RND) / INC_DEN),
        PHASE_BITS'((64'd78399 * PH_ONE + INC_RND) / INC_DEN)
    };

    // command bytes
    localparam logic [CHR_W-1:0] CH_LO_A = CHR_W'("a");
    localparam logic [CHR_W-1:0] CH_UP_A = CHR_W'("A");
    localparam logic [CHR_W-1:0] CH_LO_B = CHR_W'("b");
    localparam logic [CHR_W-1:0] CH_UP_B = CHR_W'("B");
    localparam logic [CHR_W-1:0] CH_UP_C = CHR_W'("C");
    localparam logic [CHR_W-1:0] CH_LO_D = CHR_W'("d");
    localparam logic [CHR_W-1:0] CH_UP_D = CHR_W'("D");
    localparam logic [CHR_W-1:0] CH_LO_E = CHR_W'("e");
    localparam logic [CHR_W-1:0] CH_UP_E = CHR_W'("E");
    localparam logic [CHR_W-1:0] CH_UP_F = CHR_W'("F");
    localparam logic [CHR_W-1:0] CH_LO_G = CHR_W'("g");
    localparam logic [CHR_W-1:0] CH_UP_G = CHR_W'("G");
    localparam logic [CHR_W-1:0] CH_D1   = CHR_W'("1");
    localparam logic [CHR_W-1:0] CH_D2   = CHR_W'("2");
    localparam logic [CHR_W-1:0] CH_D4   = CHR_W'("4");
    localparam logic [CHR_W-1:0] CH_D8   = CHR_W'("8");
    localparam logic [CHR_W-1:0] CH_D6   = CHR_W'("6");
    localparam logic [CHR_W-1:0] CH_PLUS  = CHR_W'("+");
    localparam logic [CHR_W-1:0] CH_MINUS = CHR_W'("-");
    localparam logic [CHR_W-1:0] CH_DOT   = CHR_W'(".");

    // sample datapath widths
    localparam int TRI_W    = PHASE_BITS + 1;
    localparam int V_W      = PHASE_BITS + 3;
    localparam int U_W      = PHASE_BITS + 1;
    localparam int LO_W     = (U_W + 1) / 2;
    localparam int HI_W     = U_W - LO_W;
    localparam int PLO_W    = VOL_W + LO_W;
    localparam int PHI_W    = VOL_W + HI_W;
    localparam int P_W      = VOL_W + U_W;
    localparam int X_W      = P_W - (PHASE_BITS - 3);
    localparam int RCP_SH   = X_W + 4;
    localparam int RCP_W    = RCP_SH - 3;
    localparam int Y_W      = X_W + RCP_W;
    localparam int Q_W      = Y_W - RCP_SH;
    localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'((64'd1 << RCP_SH) / 10 + 1);

    typedef enum logic {
        OP_CMD,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_BUSY
    } t_status;

    typedef struct packed {
        logic    note_end;
        logic    idle;
        t_status status;
    } t_flags;

endpackage

[rtl/note_sequencer_triangle_synth_core.sv]
// note sequencer with three-harmonic triangle synth, stream in and out
// depends on nsts_pkg and assert_macros.svh
// throughput: one word per cycle while the output is not stalled; sequencer state
// updates as each word moves from the input register into stage 1, and the sample
// path is a multiply and divide-by-ten pipeline of stages s1 to s5 and an output register
// reset: synchronous active low, clears pipeline valids and sequencer state except
// the duration code, which returns to 2; max_volume returns to 30000
`include "assert_macros.svh"

module note_sequencer_triangle_synth_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [14:0] i_cfg_wr_data,   // max_volume
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // command_char
    input  logic [0:0]  s_axis_tuser,    // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // sample
    output logic        m_axis_tlast,    // note_end
    output logic [2:0]  m_axis_tuser     // status[1:0], idle
);
    import nsts_pkg::*;

    // sequencer state
    logic [VOL_W-1:0]        r_vol;
    logic [PHASE_BITS-1:0]   r_phase, n_phase;
    logic [PHASE_BITS-1:0]   r_step, n_step;
    logic [SL_W-1:0]         r_left, n_left;
    logic signed [OCT_W-1:0] r_oct, n_oct;
    logic [DUR_W-1:0]        r_dur, n_dur;
    logic                    r_rest, n_rest;

    // input register
    logic             r_in_vld;
    t_op              r_in_op;
    logic [CHR_W-1:0] r_in_char;

    // pipeline stages
    logic                  r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_out_vld;
    logic [PHASE_BITS-1:0] r_s1_phase;
    logic                  r_s1_mute;
    t_flags                r_s1_flags, r_s2_flags, r_s3_flags, r_s4_flags, r_s5_flags;
    t_flags                r_out_flags;
    logic [U_W-1:0]        r_s2_u;
    logic                  r_s2_neg, r_s3_neg, r_s4_neg, r_s5_neg;
    logic [PLO_W-1:0]      r_s3_lo;
    logic [PHI_W-1:0]      r_s3_hi;
    logic [X_W-1:0]        r_s4_x;
    logic [Y_W-1:0]        r_s5_y;
    logic [SMP_W-1:0]      r_out_sample;

    logic rdy_in, rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

    // stage 1 combinational
    logic                  note_hit, dig_hit, busy;
    logic [NIDX_W-1:0]     note_idx;
    logic [DUR_W-1:0]      dig_code;
    logic [OCT_W-1:0]      oct_mag;
    logic [PHASE_BITS-1:0] note_step;
    logic                  s1_mute;
    t_flags                s1_flags;

    // stage 2 combinational
    logic signed [TRI_W-1:0] tri_a, tri_b, tri_c;
    logic signed [V_W-1:0]   v_sum;
    logic [V_W-1:0]          v_mag;

    // later stages
    logic [P_W-1:0]   p_sum;
    logic [Q_W-1:0]   q_val;
    logic [SMP_W-1:0] smp;

    function automatic logic signed [TRI_W-1:0] tri_fold(input logic [PHASE_BITS-1:0] p);
        logic [TRI_W-1:0] pe;
        logic [TRI_W-1:0] res;
        pe = {1'b0, p};
        if (p <= PHASE_BITS'(64'd1 << (PHASE_BITS - 2))) begin
            res = pe;
        end else if (p <= PHASE_BITS'(64'd3 << (PHASE_BITS - 2))) begin
            res = TRI_W'(64'd1 << (PHASE_BITS - 1)) - pe;
        end else begin
            res = pe - TRI_W'(64'd1 << PHASE_BITS);
        end
        return signed'(res);
    endfunction

    // pipeline handshake
    assign rdy_out = !r_out_vld || m_axis_tready;
    assign rdy5    = !r_s5_vld || rdy_out;
    assign rdy4    = !r_s4_vld || rdy5;
    assign rdy3    = !r_s3_vld || rdy4;
    assign rdy2    = !r_s2_vld || rdy3;
    assign rdy1    = !r_s1_vld || rdy2;
    assign rdy_in  = !r_in_vld || rdy1;

    assign s_axis_tready = rdy_in;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tlast  = r_out_flags.note_end;
    assign m_axis_tuser  = {r_out_flags.status, r_out_flags.idle};

    // command decode
    always_comb begin
        note_hit = 1'b1;
        note_idx = '0;
        case (r_in_char)
            CH_LO_A: note_idx = NIDX_W'(0);
            CH_UP_A: note_idx = NIDX_W'(1);
            CH_LO_B: note_idx = NIDX_W'(2);
            CH_UP_B: note_idx = NIDX_W'(3);
            CH_UP_C: note_idx = NIDX_W'(4);
            CH_LO_D: note_idx = NIDX_W'(5);
            CH_UP_D: note_idx = NIDX_W'(6);
            CH_LO_E: note_idx = NIDX_W'(7);
            CH_UP_E: note_idx = NIDX_W'(8);
            CH_UP_F: note_idx = NIDX_W'(9);
            CH_LO_G: note_idx = NIDX_W'(10);
            CH_UP_G: note_idx = NIDX_W'(11);
            default: note_hit = 1'b0;
        endcase
    end

    always_comb begin
        dig_hit  = 1'b1;
        dig_code = '0;
        case (r_in_char)
            CH_D1:   dig_code = DUR_W'(0);
            CH_D2:   dig_code = DUR_W'(1);
            CH_D4:   dig_code = DUR_W'(2);
            CH_D8:   dig_code = DUR_W'(3);
            CH_D6:   dig_code = DUR_W'(4);
            default: dig_hit = 1'b0;
        endcase
    end

    assign oct_mag   = r_oct[OCT_W-1] ? OCT_W'(-r_oct) : OCT_W'(r_oct);
    assign note_step = r_oct[OCT_W-1] ? (NOTE_INC[note_idx] >> oct_mag[OCT_W-2:0])
                                      : (NOTE_INC[note_idx] << oct_mag[OCT_W-2:0]);
    assign busy      = (r_left != '0);

    // sequencer next state
    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_left   = r_left;
        n_oct    = r_oct;
        n_dur    = r_dur;
        n_rest   = r_rest;
        s1_mute  = 1'b1;
        s1_flags = '{note_end: 1'b0, idle: 1'b0, status: ST_OK};
        if (r_in_op == OP_TICK) begin
            if (!busy) begin
                s1_flags.idle = 1'b1;
            end else begin
                s1_mute  = r_rest;
                n_phase  = r_phase + r_step;
                n_left   = r_left - SL_W'(1);
                s1_flags.note_end = (r_left == SL_W'(1));
            end
        end else begin
            if (note_hit || r_in_char == CH_DOT) begin
                if (busy) begin
                    s1_flags.status = ST_BUSY;
                end else begin
                    n_phase = '0;
                    n_left  = DUR_BASE >> r_dur;
                    if (note_hit) begin
                        n_step = note_step;
                        n_rest = 1'b0;
                    end else begin
                        n_rest = 1'b1;
                    end
                end
            end else if (r_in_char == CH_PLUS) begin
                if (r_oct < OCT_MAX) begin
                    n_oct = r_oct + OCT_W'(1);
                end
            end else if (r_in_char == CH_MINUS) begin
                if (r_oct > OCT_MIN) begin
                    n_oct = r_oct - OCT_W'(1);
                end
            end else if (dig_hit) begin
                n_dur = dig_code;
            end else begin
                s1_flags.status = ST_INVALID;
            end
            s1_flags.idle = (n_left == '0);
        end
    end

    // harmonic sum, in units of 2^-(PHASE_BITS-3) of the weighted triangles
    always_comb begin
        tri_a = tri_fold(r_s1_phase);
        tri_b = tri_fold({r_s1_phase[PHASE_BITS-2:0], 1'b0});
        tri_c = tri_fold({r_s1_phase[PHASE_BITS-3:0], 2'b00});
        v_sum = (V_W'(tri_a) <<< 1) + V_W'(tri_b) + (V_W'(tri_c) <<< 1) + V_W'(tri_c);
        v_mag = v_sum[V_W-1] ? V_W'(-v_sum) : V_W'(v_sum);
    end

    assign p_sum = P_W'(r_s3_lo) + (P_W'(r_s3_hi) << LO_W);
    assign q_val = r_s5_y[Y_W-1:RCP_SH];

    // truncate toward zero already done on magnitude, saturate on sign
    always_comb begin
        if (r_s5_neg) begin
            smp = (q_val > Q_W'(1 << (SMP_W - 1))) ? SMP_W'(1 << (SMP_W - 1))
                                                  : SMP_W'(-q_val);
        end else begin
            smp = (q_val > Q_W'((1 << (SMP_W - 1)) - 1)) ? SMP_W'((1 << (SMP_W - 1)) - 1)
                                                        : SMP_W'(q_val);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol     <= VOL_RESET;
            r_phase   <= '0;
            r_step    <= '0;
            r_left    <= '0;
            r_oct     <= '0;
            r_dur     <= DUR_RESET;
            r_rest    <= 1'b0;
            r_in_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vol <= i_cfg_wr_data;
            end
            if (r_in_vld && rdy1) begin
                r_phase <= n_phase;
                r_step  <= n_step;
                r_left  <= n_left;
                r_oct   <= n_oct;
                r_dur   <= n_dur;
                r_rest  <= n_rest;
            end
            if (rdy_in)  r_in_vld  <= s_axis_tvalid;
            if (rdy1)    r_s1_vld  <= r_in_vld;
            if (rdy2)    r_s2_vld  <= r_s1_vld;
            if (rdy3)    r_s3_vld  <= r_s2_vld;
            if (rdy4)    r_s4_vld  <= r_s3_vld;
            if (rdy5)    r_s5_vld  <= r_s4_vld;
            if (rdy_out) r_out_vld <= r_s5_vld;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (rdy_in) begin
            r_in_op   <= t_op'(s_axis_tuser[0]);
            r_in_char <= s_axis_tdata;
        end
        if (rdy1) begin
            r_s1_phase <= r_phase;
            r_s1_mute  <= s1_mute;
            r_s1_flags <= s1_flags;
        end
        if (rdy2) begin
            r_s2_u     <= r_s1_mute ? '0 : v_mag[U_W-1:0];
            r_s2_neg   <= !r_s1_mute && v_sum[V_W-1];
            r_s2_flags <= r_s1_flags;
        end
        if (rdy3) begin
            r_s3_lo    <= PLO_W'(r_vol) * PLO_W'(r_s2_u[LO_W-1:0]);
            r_s3_hi    <= PHI_W'(r_vol) * PHI_W'(r_s2_u[U_W-1:LO_W]);
            r_s3_neg   <= r_s2_neg;
            r_s3_flags <= r_s2_flags;
        end
        if (rdy4) begin
            r_s4_x     <= p_sum[P_W-1:P_W-X_W];
            r_s4_neg   <= r_s3_neg;
            r_s4_flags <= r_s3_flags;
        end
        if (rdy5) begin
            r_s5_y     <= Y_W'(r_s4_x) * Y_W'(RCP_MUL);
            r_s5_neg   <= r_s4_neg;
            r_s5_flags <= r_s4_flags;
        end
        if (rdy_out) begin
            r_out_sample <= smp;
            r_out_flags  <= r_s5_flags;
        end
    end

    `ASSERT_ALWAYS(a_oct_range, i_clk, i_rst_n, (r_oct <= OCT_MAX) && (r_oct >= OCT_MIN))
    `ASSERT_ALWAYS(a_dur_range, i_clk, i_rst_n, r_dur <= DUR_MAX)
    `ASSERT_ALWAYS(a_left_bound, i_clk, i_rst_n, r_left <= DUR_BASE)
    `ASSERT_IMPLY(a_end_ok, i_clk, i_rst_n, r_out_vld && r_out_flags.note_end, !r_out_flags.idle && r_out_flags.status == ST_OK)
    `ASSERT_IMPLY(a_cmd_quiet, i_clk, i_rst_n, r_out_vld && r_out_flags.status != ST_OK, r_out_sample == '0 && !r_out_flags.note_end)

endmodule
